@@ rtl/mi3_pkg.sv @@
// Shared widths, payload types and cofactor index table for the 3x3 inverse.
`default_nettype none
package mi3_pkg;

  localparam int unsigned EntryWidth   = 32;
  localparam int unsigned FractionBits = 16;
  localparam int unsigned AdjWidth     = 2 * EntryWidth + 1;
  localparam int unsigned ProdWidth    = 2 * EntryWidth + 1;
  localparam int unsigned DetWidth     = 3 * EntryWidth + 3;
  localparam int unsigned QuoBits      = EntryWidth + 2;

  // Each adjugate entry is the product of the first pair minus the product of the
  // second pair, with the cofactor sign already folded into the order.
  localparam logic [3:0] AdjIdx [9][4] = '{
    '{4'd4, 4'd8, 4'd7, 4'd5},
    '{4'd7, 4'd2, 4'd1, 4'd8},
    '{4'd1, 4'd5, 4'd4, 4'd2},
    '{4'd6, 4'd5, 4'd3, 4'd8},
    '{4'd0, 4'd8, 4'd6, 4'd2},
    '{4'd3, 4'd2, 4'd0, 4'd5},
    '{4'd3, 4'd7, 4'd6, 4'd4},
    '{4'd6, 4'd1, 4'd0, 4'd7},
    '{4'd0, 4'd4, 4'd3, 4'd1}
  };

  typedef struct packed {
    logic signed [EntryWidth-1:0] a00;
    logic signed [EntryWidth-1:0] a01;
    logic signed [EntryWidth-1:0] a02;
    logic signed [EntryWidth-1:0] a10;
    logic signed [EntryWidth-1:0] a11;
    logic signed [EntryWidth-1:0] a12;
    logic signed [EntryWidth-1:0] a20;
    logic signed [EntryWidth-1:0] a21;
    logic signed [EntryWidth-1:0] a22;
  } mi3_in_t;

  typedef struct packed {
    logic signed [EntryWidth-1:0] inv00;
    logic signed [EntryWidth-1:0] inv01;
    logic signed [EntryWidth-1:0] inv02;
    logic signed [EntryWidth-1:0] inv10;
    logic signed [EntryWidth-1:0] inv11;
    logic signed [EntryWidth-1:0] inv12;
    logic signed [EntryWidth-1:0] inv20;
    logic signed [EntryWidth-1:0] inv21;
    logic signed [EntryWidth-1:0] inv22;
    logic                         singular;
  } mi3_out_t;

  typedef struct packed {
    logic [DetWidth-1:0] mag;
    logic                neg;
    logic                zero;
  } mi3_det_t;

endpackage
`default_nettype wire

@@ rtl/mi3_adj.sv @@
// Two stage adjugate: cofactor products, then their differences.
`default_nettype none
module mi3_adj (
  input  logic                                    clk_i,
  input  logic                                    en_i,
  input  logic signed [mi3_pkg::EntryWidth-1:0]   a_i [9],
  output logic signed [mi3_pkg::AdjWidth-1:0]     adj_o [9],
  output logic signed [mi3_pkg::EntryWidth-1:0]   acol_o [3]
);

  localparam int unsigned EW = mi3_pkg::EntryWidth;
  localparam int unsigned AW = mi3_pkg::AdjWidth;

  logic signed [2*EW-1:0] prod_p_q [9];
  logic signed [2*EW-1:0] prod_n_q [9];
  logic signed [AW-1:0]   adj_q [9];
  logic signed [EW-1:0]   acol1_q [3];
  logic signed [EW-1:0]   acol2_q [3];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 9; k++) begin
        prod_p_q[k] <= a_i[mi3_pkg::AdjIdx[k][0]] * a_i[mi3_pkg::AdjIdx[k][1]];
        prod_n_q[k] <= a_i[mi3_pkg::AdjIdx[k][2]] * a_i[mi3_pkg::AdjIdx[k][3]];
        adj_q[k]    <= AW'(prod_p_q[k]) - AW'(prod_n_q[k]);
      end
      for (int j = 0; j < 3; j++) begin
        acol1_q[j] <= a_i[3*j];
        acol2_q[j] <= acol1_q[j];
      end
    end
  end

  assign adj_o  = adj_q;
  assign acol_o = acol2_q;

endmodule
`default_nettype wire

@@ rtl/mi3_det.sv @@
// Three stage determinant by first column expansion, plus sign and magnitude split.
`default_nettype none
module mi3_det (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic signed [mi3_pkg::AdjWidth-1:0]   adj_i [9],
  input  logic signed [mi3_pkg::EntryWidth-1:0] acol_i [3],
  output logic [mi3_pkg::AdjWidth-1:0]          adj_mag_o [9],
  output logic                                  adj_neg_o [9],
  output mi3_pkg::mi3_det_t                     det_o
);

  localparam int unsigned EW = mi3_pkg::EntryWidth;
  localparam int unsigned AW = mi3_pkg::AdjWidth;
  localparam int unsigned PW = mi3_pkg::ProdWidth;
  localparam int unsigned DW = mi3_pkg::DetWidth;

  logic signed [PW-1:0] pp_hi_q [3];
  logic signed [PW-1:0] pp_lo_q [3];
  logic signed [AW-1:0] adj1_q [9];
  logic signed [AW-1:0] adj2_q [9];
  logic signed [DW-1:0] det_q;
  logic [AW-1:0]        adj_mag_q [9];
  logic                 adj_neg_q [9];
  mi3_pkg::mi3_det_t    det_info_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 3; j++) begin
        pp_hi_q[j] <= acol_i[j] * $signed(adj_i[j][AW-1:EW]);
        pp_lo_q[j] <= acol_i[j] * $signed({1'b0, adj_i[j][EW-1:0]});
      end
      for (int k = 0; k < 9; k++) begin
        adj1_q[k]    <= adj_i[k];
        adj2_q[k]    <= adj1_q[k];
        adj_neg_q[k] <= adj2_q[k][AW-1];
        adj_mag_q[k] <= adj2_q[k][AW-1] ? AW'(-adj2_q[k]) : AW'(adj2_q[k]);
      end
      det_q <= ((DW'(pp_hi_q[0]) + DW'(pp_hi_q[1]) + DW'(pp_hi_q[2])) <<< EW)
             + DW'(pp_lo_q[0]) + DW'(pp_lo_q[1]) + DW'(pp_lo_q[2]);
      det_info_q.neg  <= det_q[DW-1];
      det_info_q.mag  <= det_q[DW-1] ? DW'(-det_q) : DW'(det_q);
      det_info_q.zero <= (det_q == '0);
    end
  end

  assign adj_mag_o = adj_mag_q;
  assign adj_neg_o = adj_neg_q;
  assign det_o     = det_info_q;

endmodule
`default_nettype wire

@@ rtl/mi3_div.sv @@
// Pipelined restoring divider for one inverse entry, one quotient bit per stage.
`default_nettype none
module mi3_div #(
  parameter int unsigned FRACTION_BITS = mi3_pkg::FractionBits
) (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic [mi3_pkg::AdjWidth-1:0]          num_i,
  input  logic                                  num_neg_i,
  input  mi3_pkg::mi3_det_t                     det_i,
  output logic signed [mi3_pkg::EntryWidth-1:0] res_o,
  output logic                                  zero_o
);

  localparam int unsigned EW = mi3_pkg::EntryWidth;
  localparam int unsigned DW = mi3_pkg::DetWidth;
  localparam int unsigned QB = mi3_pkg::QuoBits;
  localparam int unsigned RW = mi3_pkg::AdjWidth + 2 * FRACTION_BITS;
  localparam int unsigned CW = ((RW > DW + QB) ? RW : DW + QB) + 1;
  localparam logic [QB-1:0] Half = QB'(1) << (EW - 1);

  logic [CW-1:0] rem_q  [QB];
  logic [DW-1:0] den_q  [QB];
  logic [QB-1:0] quo_q  [QB+1];
  logic          neg_q  [QB+1];
  logic          over_q [QB+1];
  logic          zero_q [QB+1];
  logic [CW:0]   diff   [QB];
  logic [CW-1:0] num_ext;
  logic [QB-1:0] qneg;
  logic signed [EW-1:0] res_q;
  logic          zero_out_q;

  assign num_ext = CW'(num_i) << (2 * FRACTION_BITS);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= num_ext;
      den_q[0]  <= det_i.mag;
      quo_q[0]  <= '0;
      neg_q[0]  <= num_neg_i ^ det_i.neg;
      over_q[0] <= (num_ext >= (CW'(det_i.mag) << QB));
      zero_q[0] <= det_i.zero;
    end
  end

  for (genvar s = 0; s < QB; s++) begin : g_stage
    localparam int unsigned B = QB - 1 - s;
    assign diff[s] = {1'b0, rem_q[s]} - {1'b0, (CW'(den_q[s]) << B)};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[s+1]  <= quo_q[s] | (diff[s][CW] ? '0 : (QB'(1) << B));
        neg_q[s+1]  <= neg_q[s];
        over_q[s+1] <= over_q[s];
        zero_q[s+1] <= zero_q[s];
      end
    end
    if (s < QB - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s+1] <= diff[s][CW] ? rem_q[s] : diff[s][CW-1:0];
          den_q[s+1] <= den_q[s];
        end
      end
    end
  end

  assign qneg = ~quo_q[QB] + QB'(1);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_out_q <= zero_q[QB];
      if (zero_q[QB]) begin
        res_q <= '0;
      end else if (neg_q[QB]) begin
        if (over_q[QB] || quo_q[QB] > Half) begin
          res_q <= {1'b1, {(EW-1){1'b0}}};
        end else begin
          res_q <= $signed(qneg[EW-1:0]);
        end
      end else begin
        if (over_q[QB] || quo_q[QB] > Half - QB'(1)) begin
          res_q <= {1'b0, {(EW-1){1'b1}}};
        end else begin
          res_q <= $signed(quo_q[QB][EW-1:0]);
        end
      end
    end
  end

  assign res_o  = res_q;
  assign zero_o = zero_out_q;

endmodule
`default_nettype wire

@@ rtl/matrix_inverse_3x3.sv @@
// Stages from an accepted input beat to its result beat: 2 adjugate stages,
// 3 determinant stages, and 36 divider stages (one setup stage, 34 stages of one
// quotient bit each and one saturation stage).
// Throughput: one matrix per cycle; the whole pipeline advances together and holds
// while the output is stalled. Reset clears only the valid bits; the pipeline is
// ready for input in the first cycle after reset.
`default_nettype none
module matrix_inverse_3x3 #(
  parameter int unsigned FRACTION_BITS = mi3_pkg::FractionBits
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  mi3_pkg::mi3_in_t  in_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output mi3_pkg::mi3_out_t out_o
);

  localparam int unsigned EW  = mi3_pkg::EntryWidth;
  localparam int unsigned AW  = mi3_pkg::AdjWidth;
  localparam int unsigned Lat = 2 + 3 + mi3_pkg::QuoBits + 2;

  logic [Lat-1:0]        vld_q;
  logic                  en;
  logic signed [EW-1:0]  a [9];
  logic signed [AW-1:0]  adj [9];
  logic signed [EW-1:0]  acol [3];
  logic [AW-1:0]         adj_mag [9];
  logic                  adj_neg [9];
  mi3_pkg::mi3_det_t     det;
  logic signed [EW-1:0]  res [9];
  logic                  zero [9];

  assign en         = ~vld_q[Lat-1] | ~out_stall_i;
  assign in_stall_o = ~en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], in_valid_i};
    end
  end

  assign a[0] = in_i.a00;
  assign a[1] = in_i.a01;
  assign a[2] = in_i.a02;
  assign a[3] = in_i.a10;
  assign a[4] = in_i.a11;
  assign a[5] = in_i.a12;
  assign a[6] = in_i.a20;
  assign a[7] = in_i.a21;
  assign a[8] = in_i.a22;

  mi3_adj u_adj (
    .clk_i  (clk_i),
    .en_i   (en),
    .a_i    (a),
    .adj_o  (adj),
    .acol_o (acol)
  );

  mi3_det u_det (
    .clk_i     (clk_i),
    .en_i      (en),
    .adj_i     (adj),
    .acol_i    (acol),
    .adj_mag_o (adj_mag),
    .adj_neg_o (adj_neg),
    .det_o     (det)
  );

  for (genvar k = 0; k < 9; k++) begin : g_lane
    mi3_div #(
      .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
      .clk_i     (clk_i),
      .en_i      (en),
      .num_i     (adj_mag[k]),
      .num_neg_i (adj_neg[k]),
      .det_i     (det),
      .res_o     (res[k]),
      .zero_o    (zero[k])
    );
  end

  assign out_valid_o    = vld_q[Lat-1];
  assign out_o.inv00    = res[0];
  assign out_o.inv01    = res[1];
  assign out_o.inv02    = res[2];
  assign out_o.inv10    = res[3];
  assign out_o.inv11    = res[4];
  assign out_o.inv12    = res[5];
  assign out_o.inv20    = res[6];
  assign out_o.inv21    = res[7];
  assign out_o.inv22    = res[8];
  assign out_o.singular = zero[0];

`ifndef SYNTHESIS
  a_no_stall_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while output is empty");

  a_result_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_o))
    else $error("stalled result beat changed");

  a_singular_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.singular |-> out_o.inv00 == '0 && out_o.inv11 == '0
      && out_o.inv22 == '0 && out_o.inv01 == '0 && out_o.inv12 == '0)
    else $error("singular beat carries nonzero entries");
`endif

endmodule
`default_nettype wire
